[rtl/chsd_pkg.sv]
`timescale 1ns / 1ps
// chsd_pkg: constants, character helpers and sequencer states for the
// content hex segment decoder. no dependencies.
package chsd_pkg;

   localparam int SEG_MAX = 32;
   localparam int SEG_AW  = $clog2(SEG_MAX);
   localparam int LEN_W   = $clog2(SEG_MAX + 1);

   localparam logic [7:0] PIPE_CH  = 8'h7C;
   localparam logic [7:0] SPACE_CH = 8'h20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_PROC,
      ST_TAIL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       has_data;
      logic       overflow;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = is_digit(c) || ((c >= 8'h61) && (c <= 8'h66))
               || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   // letters a-f and A-F share their low nibble: 1..6 maps to 10..15
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      hex_nibble = is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
   endfunction

endpackage

[rtl/chsd_ram.sv]
`timescale 1ns / 1ps
// chsd_ram: generic single write port, single read port ram with registered read.
// no dependencies.
module chsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/content_hex_segment_decoder.sv]
`timescale 1ns / 1ps
// content_hex_segment_decoder: pipe segment hex decoder, top level.
// depends on chsd_pkg and chsd_ram.
//
//   channel | direction | tdata          | tlast          | tuser
//   req_    | in        | char_in        | end_of_string  | -
//   rsp_    | out       | byte_out       | last_of_run    | has_data, string_done, overflow
//
// a plain character is accepted, then handed over to the output register.
// a segment close walks the segment ram entry by entry (read, then decode) after the
// accept; characters inside a segment are stored in the segment ram as they are taken.
// one result is held back so the last one of a transaction can carry tlast.
// reset is synchronous and clears the sequencer and segment state; no clearing pass.
// a stalled output freezes the walk; input is not taken until the item is finished.
module content_hex_segment_decoder
   import chsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] byte_out
   output logic       rsp_tlast,
   output logic [2:0] rsp_tuser    // [0] has_data, [1] string_done, [2] overflow
);

   state_type state_ff, state_in;

   logic             in_seg_ff, in_seg_in;
   logic [LEN_W-1:0] seg_len_ff, seg_len_in;
   logic             all_hex_ff, all_hex_in;
   logic             seg_ovf_ff, seg_ovf_in;
   logic             eos_ff, eos_in;
   logic             marker_ovf_ff, marker_ovf_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [7:0]       acc_ff, acc_in;
   logic             active_ff, active_in;

   logic             pend_valid_ff, pend_valid_in;
   result_type       pend_ff, pend_in;

   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_done_ff, rsp_done_in;

   logic             accept;
   logic             can_push;
   logic             emit_req;
   logic [7:0]       emit_byte;
   logic             blocked;

   logic             ram_we;
   logic [SEG_AW-1:0] ram_waddr;
   logic             ram_re;
   logic [7:0]       ram_rdata;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign can_push   = !rsp_valid_ff || rsp_tready;

   chsd_ram #(
      .WIDTH(8),
      .DEPTH(SEG_MAX)
   ) u_seg_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(req_tdata),
      .rd_en  (ram_re),
      .rd_addr(idx_ff[SEG_AW-1:0]),
      .rd_data(ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!in_seg_ff) begin
                  if (req_tdata != PIPE_CH || req_tlast) begin
                     state_in = ST_FINISH;
                  end
               end else if (req_tdata == PIPE_CH || req_tlast) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = (idx_ff == seg_len_ff) ? ST_TAIL : ST_PROC;
         end
         ST_PROC: begin
            if (!blocked) state_in = ST_READ;
         end
         ST_TAIL: begin
            if (!blocked) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!blocked) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      in_seg_in     = in_seg_ff;
      seg_len_in    = seg_len_ff;
      all_hex_in    = all_hex_ff;
      seg_ovf_in    = seg_ovf_ff;
      eos_in        = eos_ff;
      marker_ovf_in = marker_ovf_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      active_in     = active_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      emit_req      = 1'b0;
      emit_byte     = ram_rdata;
      blocked       = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = seg_len_ff[SEG_AW-1:0];
      ram_re        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               eos_in        = req_tlast;
               marker_ovf_in = 1'b0;
               idx_in        = '0;
               acc_in        = '0;
               active_in     = 1'b0;
               if (!in_seg_ff) begin
                  if (req_tdata == PIPE_CH) begin
                     // a closing end of string here gives just the empty marker
                     in_seg_in = !req_tlast;
                  end else begin
                     pend_valid_in = 1'b1;
                     pend_in       = '{byte_out: req_tdata, has_data: 1'b1, overflow: 1'b0};
                  end
               end else if (req_tdata != PIPE_CH) begin
                  if (!is_hex(req_tdata) && req_tdata != SPACE_CH) all_hex_in = 1'b0;
                  if (seg_len_ff < LEN_W'(SEG_MAX)) begin
                     ram_we     = 1'b1;
                     seg_len_in = seg_len_ff + LEN_W'(1);
                  end else begin
                     seg_ovf_in = 1'b1;
                  end
                  marker_ovf_in = (seg_len_ff < LEN_W'(SEG_MAX)) ? seg_ovf_ff : 1'b1;
               end
            end
         end
         ST_READ: begin
            ram_re = (idx_ff != seg_len_ff);
         end
         ST_PROC: begin
            if (all_hex_ff) begin
               if (ram_rdata == SPACE_CH) begin
                  emit_req  = active_ff;
                  emit_byte = acc_ff;
               end
            end else begin
               emit_req = 1'b1;
            end
            blocked = emit_req && pend_valid_ff && !can_push;
            if (!blocked) begin
               idx_in = idx_ff + LEN_W'(1);
               if (all_hex_ff) begin
                  if (ram_rdata == SPACE_CH) begin
                     active_in = 1'b0;
                     acc_in    = '0;
                  end else begin
                     active_in = 1'b1;
                     acc_in    = {acc_ff[3:0], hex_nibble(ram_rdata)};
                  end
               end
            end
         end
         ST_TAIL: begin
            emit_req  = all_hex_ff && active_ff;
            emit_byte = acc_ff;
            blocked   = emit_req && pend_valid_ff && !can_push;
         end
         ST_FINISH: begin
            blocked = (pend_valid_ff || eos_ff) && !can_push;
            if (!blocked) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in        = pend_ff;
                  rsp_last_in   = 1'b1;
                  rsp_done_in   = eos_ff;
                  pend_valid_in = 1'b0;
               end else if (eos_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{byte_out: 8'h00, has_data: 1'b0, overflow: marker_ovf_ff};
                  rsp_last_in  = 1'b1;
                  rsp_done_in  = 1'b1;
               end
               in_seg_in  = 1'b0;
               seg_len_in = '0;
               all_hex_in = 1'b1;
               seg_ovf_in = 1'b0;
            end
         end
         default: ;
      endcase

      // hold back one result so the final one of the transaction can be marked
      if (emit_req && !blocked) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
            rsp_done_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = '{byte_out: emit_byte, has_data: 1'b1, overflow: seg_ovf_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_seg_ff     <= 1'b0;
         seg_len_ff    <= '0;
         all_hex_ff    <= 1'b1;
         seg_ovf_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_seg_ff     <= in_seg_in;
         seg_len_ff    <= seg_len_in;
         all_hex_ff    <= all_hex_in;
         seg_ovf_ff    <= seg_ovf_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      eos_ff        <= eos_in;
      marker_ovf_ff <= marker_ovf_in;
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      active_ff     <= active_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.byte_out;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ff.overflow, rsp_done_ff, rsp_ff.has_data};

   // the segment length never passes the buffer size
   assert property (@(posedge clock) disable iff (reset)
      seg_len_ff <= LEN_W'(SEG_MAX))
      else $error("segment length beyond buffer");

   // the walk index stays within the stored segment
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_PROC) |-> idx_ff <= seg_len_ff)
      else $error("walk index past segment end");

   // no held-back result survives into an idle cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind");

   // an empty marker only ever closes a string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.has_data) |-> (rsp_last_ff && rsp_done_ff))
      else $error("empty marker not at end of string");

endmodule
